### hw/rtl/aso_pkg.sv
// aso_pkg: types and constants shared by the accelerometer orientation block.
// No dependencies.
`timescale 1ns / 1ps

package aso_pkg;

    typedef enum logic [1:0] {
        RC_OK      = 2'd0,
        RC_NO_DATA = 2'd1,
        RC_ZERO    = 2'd2,
        RC_GARBAGE = 2'd3
    } aso_code_t;

    typedef enum logic [1:0] {
        OR_NORMAL = 2'd0,
        OR_UPSIDE = 2'd1,
        OR_LEFT   = 2'd2,
        OR_RIGHT  = 2'd3
    } aso_orient_t;

    typedef enum logic [1:0] {
        LAYOUT_DEFAULT = 2'd0,
        LAYOUT_SWAP_YZ = 2'd1,
        LAYOUT_SWAP_XZ = 2'd2,
        LAYOUT_SWAP_XY = 2'd3
    } aso_layout_t;

    localparam logic [1:0] CFG_AXIS_LAYOUT   = 2'd0;
    localparam logic [1:0] CFG_ORIENT_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TILT_THRESH   = 2'd2;
    localparam logic [1:0] CFG_DOM_MARGIN    = 2'd3;

    localparam logic [11:0] TILT_THRESH_RST = 12'd200;
    localparam logic [11:0] DOM_MARGIN_RST  = 12'd10;

    localparam logic [3:0] MASK_W0 = 4'h9;
    localparam logic [3:0] MASK_W1 = 4'hA;
    localparam logic [3:0] MASK_W2 = 4'hB;

    typedef struct packed {
        aso_layout_t  axis_layout;
        logic         orient_enable;
        logic [11:0]  tilt_threshold;
        logic [11:0]  dominance_margin;
    } aso_cfg_t;

    // decoded burst, as passed from front to back
    typedef struct packed {
        logic               no_data;
        logic               garbage;
        logic [2:0]         wr;
        logic signed [11:0] v0;
        logic signed [11:0] v1;
        logic signed [11:0] v2;
    } aso_item_t;

    typedef struct packed {
        aso_code_t          code;
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic signed [12:0] z;
        logic               orient_valid;
        aso_orient_t        orientation;
        logic               screen_class;
    } aso_result_t;

endpackage

### hw/rtl/accel_sample_orientation.sv
// accel_sample_orientation: burst decoder and tilt classifier, top level.
// A pushed request is stored in the request queue, then in the result queue, where it
// can be popped. Throughput: one request per cycle unless a queue is full; front
// decode, a 2-entry request queue, back update of held axes and histories, then a
// 2-entry result queue. Reset (rst_n, async low): queues empty, held axes and histories
// zero, registers at their defaults. Depends on aso_pkg, aso_front, aso_queue, aso_back.
`timescale 1ns / 1ps

module accel_sample_orientation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         pair0_high,
    input  logic [7:0]         pair0_low,
    input  logic [7:0]         pair1_high,
    input  logic [7:0]         pair1_low,
    input  logic [7:0]         pair2_high,
    input  logic [7:0]         pair2_low,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         result_code,
    output logic signed [12:0] accel_x,
    output logic signed [12:0] accel_y,
    output logic signed [12:0] accel_z,
    output logic               orient_valid,
    output logic [1:0]         orientation,
    output logic               screen_class
);

    aso_pkg::aso_cfg_t    cfg_reg, cfg_next;
    aso_pkg::aso_item_t   front_item, queue_item;
    aso_pkg::aso_result_t res;
    logic                 queue_empty, back_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                aso_pkg::CFG_AXIS_LAYOUT:
                    cfg_next.axis_layout = aso_pkg::aso_layout_t'(cfg_data[1:0]);
                aso_pkg::CFG_ORIENT_ENABLE: cfg_next.orient_enable    = cfg_data[0];
                aso_pkg::CFG_TILT_THRESH:   cfg_next.tilt_threshold   = cfg_data;
                aso_pkg::CFG_DOM_MARGIN:    cfg_next.dominance_margin = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_layout      <= aso_pkg::LAYOUT_DEFAULT;
            cfg_reg.orient_enable    <= 1'b0;
            cfg_reg.tilt_threshold   <= aso_pkg::TILT_THRESH_RST;
            cfg_reg.dominance_margin <= aso_pkg::DOM_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    aso_front u_front (
        .status_byte (status_byte),
        .pair0_high  (pair0_high),
        .pair0_low   (pair0_low),
        .pair1_high  (pair1_high),
        .pair1_low   (pair1_low),
        .pair2_high  (pair2_high),
        .pair2_low   (pair2_low),
        .item        (front_item)
    );

    aso_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_item),
        .full    (full),
        .pop     (back_take),
        .rd_data (queue_item),
        .empty   (queue_empty)
    );

    aso_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (!queue_empty),
        .in_item  (queue_item),
        .in_take  (back_take),
        .empty    (empty),
        .pop      (pop),
        .result   (res)
    );

    assign result_code  = res.code;
    assign accel_x      = res.x;
    assign accel_y      = res.y;
    assign accel_z      = res.z;
    assign orient_valid = res.orient_valid;
    assign orientation  = res.orientation;
    assign screen_class = res.screen_class;

endmodule

### hw/rtl/aso_front.sv
// aso_front: decodes one burst into axis values, write flags and reject flags.
// Depends on aso_pkg.
`timescale 1ns / 1ps

module aso_front (
    input  logic [7:0]         status_byte,
    input  logic [7:0]         pair0_high,
    input  logic [7:0]         pair0_low,
    input  logic [7:0]         pair1_high,
    input  logic [7:0]         pair1_low,
    input  logic [7:0]         pair2_high,
    input  logic [7:0]         pair2_low,
    output aso_pkg::aso_item_t item
);

    always_comb
    begin
        item.no_data = (status_byte[3:0] == 4'h0);
        item.garbage = (status_byte == pair0_high) && (status_byte == pair0_low)
                    && (status_byte == pair1_high)
                    && (pair1_low == pair2_high) && (pair1_low == pair2_low);
        item.wr[0]   = |(status_byte[3:0] & aso_pkg::MASK_W0);
        item.wr[1]   = |(status_byte[3:0] & aso_pkg::MASK_W1);
        item.wr[2]   = |(status_byte[3:0] & aso_pkg::MASK_W2);
        item.v0      = $signed({pair0_high, pair0_low[7:4]});
        item.v1      = $signed({pair1_high, pair1_low[7:4]});
        item.v2      = $signed({pair2_high, pair2_low[7:4]});
    end

endmodule

### hw/rtl/aso_queue.sv
// aso_queue: two-entry queue of decoded bursts between front and back.
// Depends on aso_pkg.
`timescale 1ns / 1ps

module aso_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aso_pkg::aso_item_t wr_data,
    output logic               full,
    input  logic               pop,
    output aso_pkg::aso_item_t rd_data,
    output logic               empty
);

    aso_pkg::aso_item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/aso_back.sv
// aso_back: axis mapping, held values, tilt histories and the result queue.
// Depends on aso_pkg.
`timescale 1ns / 1ps

module aso_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aso_pkg::aso_cfg_t   cfg,
    input  logic                in_valid,
    input  aso_pkg::aso_item_t  in_item,
    output logic                in_take,
    output logic                empty,
    input  logic                pop,
    output aso_pkg::aso_result_t result
);

    logic signed [12:0] held_x_reg, held_x_next;
    logic signed [12:0] held_y_reg, held_y_next;
    logic signed [12:0] held_z_reg, held_z_next;
    logic [3:0] hist_left_reg, hist_left_next;
    logic [3:0] hist_right_reg, hist_right_next;
    logic [3:0] hist_normal_reg, hist_normal_next;
    logic [3:0] hist_upside_reg, hist_upside_next;

    aso_pkg::aso_result_t res;
    aso_pkg::aso_result_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    logic signed [12:0] n0, n1, p0, p1, p2;
    logic signed [12:0] cx, cy, cz, ax_s, ay_s;
    logic [11:0] ax, ay;
    logic        ok, tilted, x_dom, y_dom;
    logic [3:0]  sh_left, sh_right, sh_normal, sh_upside;

    assign in_take = in_valid && (count_reg != 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign result  = mem[rd_ptr_reg];

    always_comb
    begin
        p0 = {in_item.v0[11], in_item.v0};
        p1 = {in_item.v1[11], in_item.v1};
        p2 = {in_item.v2[11], in_item.v2};
        n0 = -p0;
        n1 = -p1;
        cx = held_x_reg;
        cy = held_y_reg;
        cz = held_z_reg;
        unique case (cfg.axis_layout)
            aso_pkg::LAYOUT_SWAP_YZ:
            begin
                if (in_item.wr[0]) cx = p0;
                if (in_item.wr[1]) cz = p1;
                if (in_item.wr[2]) cy = p2;
            end
            aso_pkg::LAYOUT_SWAP_XZ:
            begin
                if (in_item.wr[0]) cz = p0;
                if (in_item.wr[1]) cy = p1;
                if (in_item.wr[2]) cx = p2;
            end
            aso_pkg::LAYOUT_SWAP_XY:
            begin
                if (in_item.wr[0]) cy = p0;
                if (in_item.wr[1]) cx = n1;
                if (in_item.wr[2]) cz = p2;
            end
            default:
            begin
                if (in_item.wr[0]) cx = n0;
                if (in_item.wr[1]) cy = n1;
                if (in_item.wr[2]) cz = p2;
            end
        endcase

        res = '0;
        if (in_item.no_data)
            res.code = aso_pkg::RC_NO_DATA;
        else if (cx == 13'sd0 && cy == 13'sd0 && cz == 13'sd0)
            res.code = aso_pkg::RC_ZERO;
        else if (in_item.garbage)
            res.code = aso_pkg::RC_GARBAGE;
        else
            res.code = aso_pkg::RC_OK;
        ok = (res.code == aso_pkg::RC_OK);

        res.x = ok ? cx : held_x_reg;
        res.y = ok ? cy : held_y_reg;
        res.z = ok ? cz : held_z_reg;

        ax_s = cx[12] ? -cx : cx;
        ay_s = cy[12] ? -cy : cy;
        ax   = ax_s[11:0];
        ay   = ay_s[11:0];
        tilted = (ax > cfg.tilt_threshold) || (ay > cfg.tilt_threshold);
        x_dom  = {1'b0, ax} > ({1'b0, ay} + {1'b0, cfg.dominance_margin});
        y_dom  = {1'b0, ay} > ({1'b0, ax} + {1'b0, cfg.dominance_margin});

        sh_left   = {hist_left_reg[2:0], 1'b0};
        sh_right  = {hist_right_reg[2:0], 1'b0};
        sh_normal = {hist_normal_reg[2:0], 1'b0};
        sh_upside = {hist_upside_reg[2:0], 1'b0};

        held_x_next      = held_x_reg;
        held_y_next      = held_y_reg;
        held_z_next      = held_z_reg;
        hist_left_next   = hist_left_reg;
        hist_right_next  = hist_right_reg;
        hist_normal_next = hist_normal_reg;
        hist_upside_next = hist_upside_reg;

        if (in_take && ok)
        begin
            held_x_next = cx;
            held_y_next = cy;
            held_z_next = cz;
            if (cfg.orient_enable)
            begin
                hist_left_next   = sh_left;
                hist_right_next  = sh_right;
                hist_normal_next = sh_normal;
                hist_upside_next = sh_upside;
                if (tilted && x_dom)
                begin
                    if (cx[12])
                    begin
                        hist_left_next = sh_left | 4'h1;
                        if (hist_left_reg[2:0] == 3'b111)
                        begin
                            hist_left_next   = 4'h0;
                            res.orient_valid = 1'b1;
                            res.orientation  = aso_pkg::OR_LEFT;
                        end
                    end
                    else
                    begin
                        hist_right_next = sh_right | 4'h1;
                        if (hist_right_reg[2:0] == 3'b111)
                        begin
                            hist_right_next  = 4'h0;
                            res.orient_valid = 1'b1;
                            res.orientation  = aso_pkg::OR_RIGHT;
                        end
                    end
                end
                else if (tilted && y_dom)
                begin
                    if (cy[12])
                    begin
                        hist_normal_next = sh_normal | 4'h1;
                        if (hist_normal_reg[2:0] == 3'b111)
                        begin
                            hist_normal_next = 4'h0;
                            res.orient_valid = 1'b1;
                            res.orientation  = aso_pkg::OR_NORMAL;
                        end
                    end
                    else
                    begin
                        hist_upside_next = sh_upside | 4'h1;
                        if (hist_upside_reg[2:0] == 3'b111)
                        begin
                            hist_upside_next = 4'h0;
                            res.orient_valid = 1'b1;
                            res.orientation  = aso_pkg::OR_UPSIDE;
                        end
                    end
                end
            end
        end
        res.screen_class = res.orient_valid && (res.orientation == aso_pkg::OR_LEFT
                                             || res.orientation == aso_pkg::OR_RIGHT);

        count_next = count_reg + {1'b0, in_take} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_z_reg      <= '0;
            hist_left_reg   <= '0;
            hist_right_reg  <= '0;
            hist_normal_reg <= '0;
            hist_upside_reg <= '0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            held_z_reg      <= held_z_next;
            hist_left_reg   <= hist_left_next;
            hist_right_reg  <= hist_right_next;
            hist_normal_reg <= hist_normal_next;
            hist_upside_reg <= hist_upside_next;
            wr_ptr_reg      <= in_take ? ~wr_ptr_reg : wr_ptr_reg;
            rd_ptr_reg      <= do_pop ? ~rd_ptr_reg : rd_ptr_reg;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

endmodule
